### rtl/nsbd_pkg.sv
`timescale 1ns / 1ps
package nsbd_pkg;

	localparam int unsigned IdW  = 32;
	localparam int unsigned DegW = 32;

	typedef logic [IdW-1:0]  id_t;
	typedef logic [DegW-1:0] deg_t;

	typedef struct packed {
		id_t  id;
		deg_t degree;
	} pair_t;

	// Broadcast from the top level to every cell of the chain.
	typedef struct packed {
		logic  ins;      // insert new_pair this cycle
		logic  shl;      // shift the chain one place toward the head
		pair_t new_pair;
	} cell_ctrl_t;

endpackage

### rtl/nsbd_in_if.sv
`timescale 1ns / 1ps
interface nsbd_in_if;
	logic                 valid;
	logic                 ready;
	logic [31:0]          vertex_id;
	logic [31:0]          degree;
	logic                 last;

	modport source (output valid, output vertex_id, output degree, output last, input ready);
	modport sink   (input valid, input vertex_id, input degree, input last, output ready);
endinterface

### rtl/nsbd_out_if.sv
`timescale 1ns / 1ps
interface nsbd_out_if;
	logic                 valid;
	logic                 ready;
	logic [31:0]          sorted_id;
	logic [31:0]          sorted_degree;
	logic                 end_of_list;
	logic                 overflow;

	modport source (output valid, output sorted_id, output sorted_degree,
		output end_of_list, output overflow, input ready);
	modport sink   (input valid, input sorted_id, input sorted_degree,
		input end_of_list, input overflow, output ready);
endinterface

### rtl/nsbd_cell.sv
`timescale 1ns / 1ps
module nsbd_cell (
	input  logic               clk,
	input  nsbd_pkg::cell_ctrl_t ctrl,
	input  logic               valid,
	input  logic               left_take,
	input  nsbd_pkg::pair_t    left_pair,
	input  nsbd_pkg::pair_t    right_pair,
	output logic               take,
	output nsbd_pkg::pair_t    pair
);
	import nsbd_pkg::*;

	pair_t pair_q;

	// Take the new pair (or the left neighbor's) unless this entry ranks at or above it.
	assign take = ctrl.ins && !(valid && (pair_q.degree >= ctrl.new_pair.degree));
	assign pair = pair_q;

	always_ff @(posedge clk) begin
		if (ctrl.shl) begin
			pair_q <= right_pair;
		end else if (ctrl.ins) begin
			if (left_take) begin
				pair_q <= left_pair;
			end else if (take) begin
				pair_q <= ctrl.new_pair;
			end
		end
	end
endmodule

### rtl/neighbor_sort_by_degree.sv
`timescale 1ns / 1ps
// Neighbor sort by degree.
//
// nbr (sink): one neighbor list as a run of items, each a vertex id and its
// degree; last marks the final item. Items are taken one per cycle into a
// chain of compare cells that keeps the list ordered by degree, largest
// first, with equal degrees in arrival order. Up to MAX_ENTRIES items are
// kept; later ones are dropped and the overflow bit is raised.
// sorted (source): on the last item the chain drains from its head, one
// result per cycle, through an output register. end_of_list marks the final
// result; overflow is the same on every result of a list.
// Once the last item is accepted, drain_q is set, and the head pair then
// moves into the output register; the chain drains by one shift per stored
// pair. nbr.ready is low while the chain drains, and rises once the final
// pair has moved into the output register.
// A stall on sorted holds the output register and freezes the drain.
// Reset (arst_n low) empties the chain, clears overflow and the output valid.
module neighbor_sort_by_degree #(
	parameter int unsigned MAX_ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	nsbd_in_if.sink     nbr,
	nsbd_out_if.source  sorted
);
	import nsbd_pkg::*;

	localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

	logic [CntW-1:0] fill_q;
	logic            overflow_q;
	logic            drain_q;

	pair_t           out_pair_q;
	logic            out_valid_q;
	logic            out_end_q;
	logic            out_ovf_q;

	cell_ctrl_t      ctrl;
	pair_t           cell_pair [MAX_ENTRIES];
	logic            cell_take [MAX_ENTRIES];

	logic            accept;
	logic            full;
	logic            advance;

	assign nbr.ready = !drain_q;
	assign accept    = nbr.valid && !drain_q;
	assign full      = (fill_q == CntW'(MAX_ENTRIES));
	// Move the head cell into the output register when that register is empty or being read.
	assign advance   = drain_q && (fill_q != '0) && (!out_valid_q || sorted.ready);

	assign ctrl.ins             = accept && !full;
	assign ctrl.shl             = advance;
	assign ctrl.new_pair.id     = nbr.vertex_id;
	assign ctrl.new_pair.degree = nbr.degree;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic  valid;
		logic  left_take;
		pair_t left_pair;
		pair_t right_pair;

		assign valid = (CntW'(i) < fill_q);

		if (i == 0) begin : g_head
			assign left_take = 1'b0;
			assign left_pair = '0;
		end else begin : g_body
			assign left_take = cell_take[i-1];
			assign left_pair = cell_pair[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign right_pair = '0;
		end else begin : g_inner
			assign right_pair = cell_pair[i+1];
		end

		nsbd_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.valid      (valid),
			.left_take  (left_take),
			.left_pair  (left_pair),
			.right_pair (right_pair),
			.take       (cell_take[i]),
			.pair       (cell_pair[i])
		);
	end

	// Control: fill count, overflow, the drain phase and the output flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			overflow_q  <= 1'b0;
			drain_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_end_q   <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (accept) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					fill_q <= fill_q + CntW'(1);
				end
				if (nbr.last) begin
					drain_q <= 1'b1;
				end
			end

			if (advance) begin
				out_valid_q <= 1'b1;
				out_end_q   <= (fill_q == CntW'(1));
				out_ovf_q   <= overflow_q;
				fill_q      <= fill_q - CntW'(1);
				// The final pair leaves: end the list and open the input again.
				if (fill_q == CntW'(1)) begin
					drain_q    <= 1'b0;
					overflow_q <= 1'b0;
				end
			end else if (sorted.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload: hold while stalled.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_pair_q <= cell_pair[0];
		end
	end

	assign sorted.valid         = out_valid_q;
	assign sorted.sorted_id     = out_pair_q.id;
	assign sorted.sorted_degree = out_pair_q.degree;
	assign sorted.end_of_list   = out_end_q;
	assign sorted.overflow      = out_ovf_q;

endmodule

### dv/tb_neighbor_sort_by_degree.sv
`timescale 1ns / 1ps
module tb_neighbor_sort_by_degree;
	import nsbd_pkg::*;

	localparam int unsigned Depth      = 32;   // MAX_ENTRIES of the block under test
	localparam int unsigned HoldCycles = 150;  // long receiver hold-off
	localparam int unsigned IdleLimit  = 2000; // cycles without any handshake
	localparam int unsigned TailCycles = Depth + 8;
	localparam int unsigned RandItems  = 20;

	// How degrees are drawn for a random list: the full range, a narrow
	// range that forces many equal keys, or only the ends of the range.
	typedef enum logic [1:0] {
		KEY_FULL,
		KEY_NARROW,
		KEY_EXTREME
	} key_mode_t;

	typedef struct packed {
		id_t  id;
		deg_t degree;
		logic end_of_list;
		logic overflow;
	} sorted_item_t;

	logic clk = 1'b0;
	logic arst_n;

	nsbd_in_if  nbr_if ();
	nsbd_out_if sorted_if ();

	neighbor_sort_by_degree #(
		.MAX_ENTRIES(Depth)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.nbr    (nbr_if),
		.sorted (sorted_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shared state between stimulus, receiver and checker.
	bit           gaps_on  = 1'b1; // random idle cycles on both sides
	bit           hold_req = 1'b0; // ask the receiver for one long hold-off
	int unsigned  mismatches;
	int unsigned  items_sent;
	int unsigned  results_seen;
	int unsigned  lists_done;
	int unsigned  overflow_lists;

	// Own model of the compare chain: pairs kept in descending degree order,
	// equal degrees in arrival order.
	id_t          chain_id [Depth];
	deg_t         chain_degree [Depth];
	int unsigned  chain_fill;
	bit           chain_overflow;
	sorted_item_t sorted_expect[$];

	// Pairs of the list being built by a test, sent by send_list.
	pair_t        list_buf[$];

	// Insert one accepted item into the model chain; on a last item, queue
	// the whole chain as expected results and empty it.
	function automatic void predict_item(id_t id, deg_t dg, logic lst);
		int unsigned  slot;
		int unsigned  k;
		sorted_item_t res;
		if (chain_fill >= Depth) begin
			// Chain full: drop the pair, flag the list.
			chain_overflow = 1'b1;
		end else begin
			slot = 0;
			while (slot < chain_fill && chain_degree[slot] >= dg)
				slot++;
			for (k = chain_fill; k > slot; k--) begin
				chain_id[k]     = chain_id[k-1];
				chain_degree[k] = chain_degree[k-1];
			end
			chain_id[slot]     = id;
			chain_degree[slot] = dg;
			chain_fill++;
		end
		if (lst) begin
			for (k = 0; k < chain_fill; k++) begin
				res.id          = chain_id[k];
				res.degree      = chain_degree[k];
				res.end_of_list = (k + 1 == chain_fill);
				res.overflow    = chain_overflow;
				sorted_expect.push_back(res);
			end
			lists_done++;
			if (chain_overflow)
				overflow_lists++;
			chain_fill     = 0;
			chain_overflow = 1'b0;
		end
	endfunction

	function automatic deg_t pick_degree(key_mode_t mode);
		case (mode)
			KEY_NARROW:  return deg_t'($urandom_range(0, 5));
			KEY_EXTREME: begin
				case ($urandom_range(0, 3))
					0:       return '0;
					1:       return deg_t'(1);
					2:       return '1 - deg_t'(1);
					default: return '1;
				endcase
			end
			default:     return deg_t'($urandom);
		endcase
	endfunction

	function automatic void check_field(string field, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// Offer one item and hold it until the block takes it. Valid stays high
	// on return so that a following item goes out back to back; an idle
	// cycle or wait_drained lowers it.
	task automatic send_item(input id_t id, input deg_t dg, input logic lst);
		while (gaps_on && $urandom_range(0, 99) < 17) begin
			nbr_if.valid <= 1'b0;
			@(posedge clk);
		end
		nbr_if.valid     <= 1'b1;
		nbr_if.vertex_id <= id;
		nbr_if.degree    <= dg;
		nbr_if.last      <= lst;
		do
			@(posedge clk);
		while (!nbr_if.ready);
		predict_item(id, dg, lst);
		items_sent++;
	endtask

	task automatic queue_pair(input id_t id, input deg_t dg);
		pair_t p;
		p.id     = id;
		p.degree = dg;
		list_buf.push_back(p);
	endtask

	// Send list_buf as one list, last set on its final item, then clear it.
	task automatic send_list();
		int unsigned k;
		for (k = 0; k < list_buf.size(); k++)
			send_item(list_buf[k].id, list_buf[k].degree, k + 1 == list_buf.size());
		list_buf.delete();
	endtask

	task automatic build_random_list(input int unsigned len, input key_mode_t mode);
		int unsigned k;
		for (k = 0; k < len; k++)
			queue_pair(id_t'($urandom), pick_degree(mode));
	endtask

	// Drop valid and wait until every expected result has come out.
	task automatic wait_drained();
		nbr_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (sorted_expect.size() != 0);
	endtask

	// Single-item lists, field extremes, equal keys and both key orders.
	task automatic test_directed();
		queue_pair('0, '0);
		send_list();
		queue_pair('1, '1);
		send_list();
		// Larger key after smaller, tie with an earlier key, zero key.
		queue_pair(32'hAAAA_AAAA, 32'd5);
		queue_pair(32'h5555_5555, 32'hFFFF_FFFF);
		queue_pair(32'h0000_0001, 32'd0);
		queue_pair(32'h8000_0000, 32'd5);
		send_list();
		// All keys equal: results must come out in arrival order.
		queue_pair(32'd1, 32'd7);
		queue_pair(32'd2, 32'd7);
		queue_pair(32'd3, 32'd7);
		queue_pair(32'd4, 32'd7);
		send_list();
		// Rising keys come out reversed, falling keys unchanged.
		queue_pair(32'd10, 32'd1);
		queue_pair(32'd11, 32'd2);
		queue_pair(32'd12, 32'h7FFF_FFFF);
		queue_pair(32'd13, 32'h8000_0000);
		send_list();
		queue_pair(32'd20, 32'hFFFF_FFFF);
		queue_pair(32'd21, 32'hFFFF_FFFE);
		queue_pair(32'd22, 32'd0);
		send_list();
		wait_drained();
	endtask

	// Exactly full, over by a few, and over by one where the dropped item is
	// the one that ends the list.
	task automatic test_capacity();
		build_random_list(Depth, KEY_FULL);
		send_list();
		build_random_list(Depth + 3, KEY_NARROW);
		send_list();
		build_random_list(Depth + 1, KEY_EXTREME);
		send_list();
		wait_drained();
	endtask

	// Stall the output for a long stretch while a full list drains and the
	// next list is offered, so that the block stalls its input.
	task automatic test_output_stall();
		hold_req = 1'b1;
		build_random_list(Depth, KEY_FULL);
		send_list();
		build_random_list(5, KEY_NARROW);
		send_list();
		wait_drained();
	endtask

	// No idle cycles on either side: lists follow each other back to back.
	task automatic test_back_to_back();
		int unsigned n;
		gaps_on = 1'b0;
		for (n = 0; n < 8; n++) begin
			build_random_list($urandom_range(1, 8), key_mode_t'($urandom_range(0, 2)));
			send_list();
		end
		wait_drained();
		gaps_on = 1'b1;
	endtask

	// Random lists: mostly short, a few around and past capacity; now and
	// then pause the sender until the block is empty.
	task automatic test_random_lists();
		int unsigned start;
		int unsigned len;
		start = items_sent;
		while (items_sent - start < RandItems) begin
			if ($urandom_range(0, 99) < 8)
				len = $urandom_range(Depth - 1, Depth + 4);
			else
				len = $urandom_range(1, 10);
			build_random_list(len, key_mode_t'($urandom_range(0, 2)));
			send_list();
			if ($urandom_range(0, 99) < 20)
				wait_drained();
		end
		wait_drained();
	endtask

	// Receiver: random ready with the same idle rate, or one long hold-off
	// when a test asks for it.
	initial begin : receiver
		sorted_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				sorted_if.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				sorted_if.ready <= !(gaps_on && $urandom_range(0, 99) < 17);
			end
		end
	end

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		sorted_item_t want;
		if (arst_n && sorted_if.valid && sorted_if.ready) begin
			results_seen++;
			if (sorted_expect.size() == 0) begin
				$display("%0t: unexpected result id %h degree %h end %b overflow %b",
					$time, sorted_if.sorted_id, sorted_if.sorted_degree,
					sorted_if.end_of_list, sorted_if.overflow);
				mismatches++;
			end else begin
				want = sorted_expect.pop_front();
				check_field("sorted_id", sorted_if.sorted_id, want.id);
				check_field("sorted_degree", sorted_if.sorted_degree, want.degree);
				check_field("end_of_list", 32'(sorted_if.end_of_list), 32'(want.end_of_list));
				check_field("overflow", 32'(sorted_if.overflow), 32'(want.overflow));
			end
		end
	end

	// Watchdog: end the run when no handshake happens for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < IdleLimit) begin
			@(posedge clk);
			if ((nbr_if.valid && nbr_if.ready) || (sorted_if.valid && sorted_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles", $time, IdleLimit);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		nbr_if.valid     = 1'b0;
		nbr_if.vertex_id = '0;
		nbr_if.degree    = '0;
		nbr_if.last      = 1'b0;
		arst_n           = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_capacity();
		test_output_stall();
		test_back_to_back();
		test_random_lists();

		// Let any stray result show up before the final verdict.
		wait_drained();
		repeat (TailCycles) @(posedge clk);
		if (sorted_expect.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sorted_expect.size());
			mismatches++;
		end

		$display("Sent %0d items in %0d lists, %0d of them past capacity.",
			items_sent, lists_done, overflow_lists);
		$display("Checked %0d results, including a long output stall and back-to-back lists.",
			results_seen);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### sim.f
rtl/nsbd_pkg.sv
rtl/nsbd_in_if.sv
rtl/nsbd_out_if.sv
rtl/nsbd_cell.sv
rtl/neighbor_sort_by_degree.sv
dv/tb_neighbor_sort_by_degree.sv
